// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file sles_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/sles_pkg.sv =====
// Types and constants for the sorted log entry store.
// No dependencies.
package sles_pkg;
    localparam int Depth     = 256;
    localparam int AddrW     = 8;
    localparam int CountW    = 9;
    localparam int NameBytes = 8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADTYPE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;
    localparam logic [1:0] TYPE_BAD   = 2'd3;
    localparam logic       MODE_INS   = 1'b0;

    typedef struct packed {
        logic        mode;
        logic [63:0] room_key;
        logic [1:0]  reading_type;
        logic signed [31:0] stamp;
        logic [31:0] value_word0;
        logic [31:0] value_word1;
        logic [31:0] value_word2;
        logic [7:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  position;
        logic [8:0]  entry_count;
        logic [63:0] out_room_key;
        logic [1:0]  out_type;
        logic signed [31:0] out_stamp;
        logic [31:0] out_word0;
        logic [31:0] out_word1;
        logic [31:0] out_word2;
    } t_out_item;

    // one stored entry
    typedef struct packed {
        logic [63:0] key;
        logic [1:0]  typ;
        logic [31:0] stamp;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
    } t_entry;

    // keep top NameBytes bytes, clear everything after first zero byte
    function automatic logic [63:0] norm_key(input logic [63:0] k);
        logic [63:0] r;
        logic        stop;
        r = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= NameBytes || k[63-8*i -: 8] == 8'd0) stop = 1'b1;
            if (!stop) r[63-8*i -: 8] = k[63-8*i -: 8];
        end
        return r;
    endfunction

    // a sorts strictly before b
    function automatic logic less_than(input t_entry a, input t_entry b);
        if (a.key != b.key) return a.key < b.key;
        if (a.typ != b.typ) return a.typ < b.typ;
        return $signed(a.stamp) < $signed(b.stamp);
    endfunction
endpackage

// ===== sv/sorted_log_entry_store_core.sv =====
// Sorted log entry store: one entry memory with a read/modify/write sequencer.
// Depends on sles_pkg.
// Usage:
//   Raise start with an item on i_in while busy is low; the item is taken
//   at that edge. Exactly one result follows on o_out, marked by o_done for one
//   cycle; the receiver cannot hold it off.
//   Read (mode 1): memory read, then result register, then done state.
//   Insert (mode 0): the sequencer scans the memory from the top entry down,
//   one entry a cycle, moving each larger entry up one place, until it meets
//   an entry not greater than the new one or reaches slot 0; it then writes the new entry.
//   An insert at position p with n entries held moves n-p entries up first.
//   Refused inserts (bad type, store full) go straight to the done state.
//   The memory's single read of one entry per cycle sets the scan pace.
//   Reset clears the state, o_done and the fill count; the memory needs no
//   clearing, since only entries below the count are ever used. busy is
//   high from accept until the result cycle begins.
module sorted_log_entry_store_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sles_pkg::t_in_item  i_in,
    output logic               o_done,
    output sles_pkg::t_out_item o_out
);
    import sles_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // read data valid in r_rdata
    localparam logic [2:0] S_SCAN = 3'd2;  // compare entry at r_ptr-1
    localparam logic [2:0] S_DONE = 3'd3;

    t_entry mem [Depth];
    t_entry r_rdata;

    logic [2:0]        r_state;
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] r_ptr;   // free slot to be written; r_rdata holds entry r_ptr-1
    t_entry            r_new;
    logic [7:0]        r_ridx;
    t_out_item         r_out;
    logic              r_done;

    logic              rd_en, wr_en;
    logic [AddrW-1:0]  rd_addr, wr_addr;
    t_entry            wr_data;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    // read address: r_count-1 on insert accept, r_ptr-2 during scan; index on read
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_new;
        if (r_state == S_IDLE && start && i_in.mode != MODE_INS) begin
            rd_en   = 1'b1;
            rd_addr = i_in.read_index;
        end else if (r_state == S_IDLE && start) begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(r_count - CountW'(1));
        end else if (r_state == S_SCAN) begin
            // r_rdata holds entry r_ptr-1
            if (r_ptr != '0 && less_than(r_new, r_rdata)) begin
                wr_en   = 1'b1;
                wr_addr = r_ptr[AddrW-1:0];
                wr_data = r_rdata;
                rd_en   = 1'b1;
                rd_addr = AddrW'(r_ptr - CountW'(2));
            end else begin
                wr_en   = 1'b1;
                wr_addr = r_ptr[AddrW-1:0];
                wr_data = r_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_ridx <= i_in.read_index;
                        r_new  <= '{key: norm_key(i_in.room_key), typ: i_in.reading_type,
                                   stamp: i_in.stamp, w0: i_in.value_word0,
                                   w1: i_in.value_word1, w2: i_in.value_word2};
                        r_ptr  <= r_count;
                        if (i_in.mode != MODE_INS) begin
                            r_out   <= '0;
                            r_state <= S_RD;
                        end else if (i_in.reading_type == TYPE_BAD) begin
                            r_out   <= '{status: ST_BADTYPE, entry_count: r_count,
                                         default: '0};
                            r_state <= S_DONE;
                        end else if (r_count == CountW'(Depth)) begin
                            r_out   <= '{status: ST_FULL, entry_count: r_count,
                                         default: '0};
                            r_state <= S_DONE;
                        end else begin
                            r_out   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_RD: begin
                    r_out.position    <= r_ridx;
                    r_out.entry_count <= r_count;
                    if (CountW'(r_ridx) >= r_count) begin
                        r_out.status <= ST_RANGE;
                    end else begin
                        r_out.status       <= ST_OK;
                        r_out.out_room_key <= r_rdata.key;
                        r_out.out_type     <= r_rdata.typ;
                        r_out.out_stamp    <= r_rdata.stamp;
                        r_out.out_word0    <= r_rdata.w0;
                        r_out.out_word1    <= r_rdata.w1;
                        r_out.out_word2    <= r_rdata.w2;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (r_ptr != '0 && less_than(r_new, r_rdata)) begin
                        r_ptr <= r_ptr - CountW'(1);
                    end else begin
                        r_out.status      <= ST_OK;
                        r_out.position    <= r_ptr[AddrW-1:0];
                        r_out.entry_count <= r_count + CountW'(1);
                        r_count           <= r_count + CountW'(1);
                        r_state           <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/sles_checker.sv =====
// Port-level checker for the sorted log entry store, with its bind.
// Depends on sles_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sles_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input sles_pkg::t_out_item o_out
);
    import sles_pkg::*;

    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised on accept")
    `CHK_IMPL(a_done_busy, i_clk, i_rst_n, o_done, !busy, "result while still busy")
    `CHK_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe held")
    `CHK_IMPL(a_count_max, i_clk, i_rst_n, o_done, o_out.entry_count <= 9'(Depth),
              "entry count beyond depth")
    `CHK_IMPL(a_full_count, i_clk, i_rst_n, o_done && o_out.status == ST_FULL,
              o_out.entry_count == 9'(Depth), "full refusal below depth")
endmodule

bind sorted_log_entry_store_core sles_checker u_sles_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_out(o_out)
);
